// ===== rtl/core/adc_trimmed_mean_ascii_defines.svh =====
// assertion macros for the trimmed mean block
`ifndef ADC_TRIMMED_MEAN_ASCII_DEFINES_SVH
`define ADC_TRIMMED_MEAN_ASCII_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ATM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ATM_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ATM_ASSERT_IMP(label, clk, rstn, ante, cons)
`define ATM_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/atm_pkg.sv =====
package atm_pkg;

    // block configuration
    localparam int WINDOW   = 10;
    localparam int CHANNELS = 8;

    // field widths
    localparam int CH_W     = 3;
    localparam int RAW_W    = 12;
    localparam int MV_W     = 12;
    localparam int SUM_W    = 16;
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TRIM_W   = MV_W + 1;

    // millivolt scaling: raw * 3300 / 4096
    localparam int MV_SCALE   = 3300;
    localparam int MV_SHIFT   = 12;
    localparam int MV_PROD_W  = RAW_W + 12;
    localparam logic [MV_W-1:0] MIN_INIT = 12'hFFF;
    localparam logic [MV_W-1:0] MV_MAX   = 12'd3299;

    // divide by WINDOW-2 through an exact reciprocal
    localparam int MEAN_DIV    = WINDOW - 2;
    localparam int MEAN_L      = $clog2(MEAN_DIV);
    localparam int MEAN_SH     = SUM_W + MEAN_L;
    localparam int MEAN_REC_W  = SUM_W + 1;
    localparam int MEAN_REC    = ((1 << MEAN_SH) + MEAN_DIV - 1) / MEAN_DIV;
    localparam int MEAN_PROD_W = SUM_W + MEAN_REC_W;

    // decimal split of a 12-bit mean through exact reciprocals
    localparam int DEC_REC_W  = 13;
    localparam int DEC_PROD_W = MV_W + DEC_REC_W;
    localparam int Div1000    = 1000;
    localparam int Div100     = 100;
    localparam int Div10      = 10;
    localparam int SH_1000    = MV_W + $clog2(Div1000);
    localparam int SH_100     = MV_W + $clog2(Div100);
    localparam int SH_10      = MV_W + $clog2(Div10);
    localparam int REC_1000   = ((1 << SH_1000) + Div1000 - 1) / Div1000;
    localparam int REC_100    = ((1 << SH_100) + Div100 - 1) / Div100;
    localparam int REC_10     = ((1 << SH_10) + Div10 - 1) / Div10;
    localparam int Q1000_W    = DEC_PROD_W - SH_1000;
    localparam int Q100_W     = DEC_PROD_W - SH_100;
    localparam int Q10_W      = DEC_PROD_W - SH_10;

    // text byte positions
    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] BYTE_HASH = 3'd0;
    localparam logic [IDX_W-1:0] BYTE_THOU = 3'd1;
    localparam logic [IDX_W-1:0] BYTE_DOT  = 3'd2;
    localparam logic [IDX_W-1:0] BYTE_HUND = 3'd3;
    localparam logic [IDX_W-1:0] BYTE_TENS = 3'd4;
    localparam logic [IDX_W-1:0] BYTE_ONES = 3'd5;
    localparam logic [IDX_W-1:0] BYTE_PCT  = 3'd6;
    localparam logic [IDX_W-1:0] BYTE_CR   = 3'd7;

    // ascii codes
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_PCT  = 8'h25;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;

    // completed window handed from the channel store to the formatter
    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [SUM_W-1:0] sum_val;
        logic [MV_W-1:0]  min_val;
        logic [MV_W-1:0]  max_val;
    } job_t;

endpackage

// ===== rtl/core/adc_trimmed_mean_ascii.sv =====
// path: a window-closing sample passes the input register, stage a and stage b before the emitter
//   shows its first text byte, then one byte per cycle while m_ready is high, 8 bytes in all
// throughput: one sample per cycle; the per-channel store does its read-modify-write as the
//   sample leaves the input register, and a window-closing sample waits only while the text emitter
//   and its two feeding stages are all occupied
// reset: synchronous active-low aresetn clears all channel stores and empties the pipeline
`include "adc_trimmed_mean_ascii_defines.svh"

module adc_trimmed_mean_ascii (
    input  logic                        aclk,
    input  logic                        aresetn,
    // sample channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [atm_pkg::CH_W-1:0]    s_channel,
    input  logic [atm_pkg::RAW_W-1:0]   s_raw_sample,
    // text channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_ascii_char,
    output logic [atm_pkg::CH_W-1:0]    m_out_channel,
    output logic [atm_pkg::MV_W-1:0]    m_mean_millivolts,
    output logic                        m_last
);

    // input register, holds one accepted transaction
    logic                        in_valid_reg;
    logic [atm_pkg::CH_W-1:0]    in_ch_reg;
    logic [atm_pkg::RAW_W-1:0]   in_raw_reg;

    atm_pkg::job_t job;
    logic          window_done;
    logic          job_valid;
    logic          job_ready;
    logic          in_adv;

    // a sample leaves the input register unless it closes a window while the
    // formatter has no room for another one
    assign in_adv    = in_valid_reg && (!window_done || job_ready);
    assign s_ready   = !in_valid_reg || in_adv;
    assign job_valid = in_valid_reg && window_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_ch_reg  <= s_channel;
            in_raw_reg <= s_raw_sample;
        end
    end

    // per-channel sum, min, max and count, updated as the sample leaves
    atm_chan_store u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .upd_en      (in_adv),
        .channel     (in_ch_reg),
        .raw_sample  (in_raw_reg),
        .job         (job),
        .window_done (window_done)
    );

    // trimmed mean, decimal split and byte emitter
    atm_text_fmt u_fmt (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .job_valid         (job_valid),
        .job               (job),
        .job_ready         (job_ready),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_ascii_char      (m_ascii_char),
        .m_out_channel     (m_out_channel),
        .m_mean_millivolts (m_mean_millivolts),
        .m_last            (m_last)
    );

    // input stalls only behind a window-closing sample with the formatter full
    `ATM_ASSERT_IMP(a_stall_cause, aclk, aresetn, !s_ready, in_valid_reg && window_done && !job_ready)
    // the mean never exceeds the largest scaled sample
    `ATM_ASSERT_IMP(a_mean_range, aclk, aresetn, m_valid, m_mean_millivolts <= atm_pkg::MV_MAX)
    // the closing byte is always a carriage return
    `ATM_ASSERT_IMP(a_last_cr, aclk, aresetn, m_valid && m_last, m_ascii_char == atm_pkg::CHAR_CR)
    // a text is never cut short
    `ATM_ASSERT_NXT(a_text_whole, aclk, aresetn, m_valid && m_ready && !m_last, m_valid)

endmodule

// ===== rtl/core/atm_chan_store.sv =====
module atm_chan_store (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         upd_en,
    input  logic [atm_pkg::CH_W-1:0]     channel,
    input  logic [atm_pkg::RAW_W-1:0]    raw_sample,
    output atm_pkg::job_t                job,
    output logic                         window_done
);

    logic [atm_pkg::SUM_W-1:0] sum_reg [atm_pkg::CHANNELS];
    logic [atm_pkg::MV_W-1:0]  min_reg [atm_pkg::CHANNELS];
    logic [atm_pkg::MV_W-1:0]  max_reg [atm_pkg::CHANNELS];
    logic [atm_pkg::CNT_W-1:0] cnt_reg [atm_pkg::CHANNELS];

    logic [atm_pkg::CH_IDX_W-1:0]  idx;
    logic                          in_range;
    logic [atm_pkg::MV_PROD_W-1:0] mv_prod;
    logic [atm_pkg::MV_W-1:0]      mv;
    logic [atm_pkg::SUM_W-1:0]     sum_upd, sum_next;
    logic [atm_pkg::MV_W-1:0]      min_upd, min_next;
    logic [atm_pkg::MV_W-1:0]      max_upd, max_next;
    logic [atm_pkg::CNT_W-1:0]     cnt_upd, cnt_next;
    logic                          full;

    assign idx      = atm_pkg::CH_IDX_W'(channel);
    assign in_range = int'(channel) < atm_pkg::CHANNELS;

    assign mv_prod = atm_pkg::MV_PROD_W'(raw_sample)
                   * atm_pkg::MV_PROD_W'(atm_pkg::MV_SCALE);
    assign mv      = atm_pkg::MV_W'(mv_prod >> atm_pkg::MV_SHIFT);

    always_comb begin
        sum_upd = sum_reg[idx] + atm_pkg::SUM_W'(mv);
        min_upd = (mv < min_reg[idx]) ? mv : min_reg[idx];
        max_upd = (mv > max_reg[idx]) ? mv : max_reg[idx];
        cnt_upd = cnt_reg[idx] + atm_pkg::CNT_W'(1);
        full    = cnt_upd == atm_pkg::CNT_W'(atm_pkg::WINDOW);
        // restart the channel once its window is handed on
        sum_next = full ? '0 : sum_upd;
        min_next = full ? atm_pkg::MIN_INIT : min_upd;
        max_next = full ? '0 : max_upd;
        cnt_next = full ? '0 : cnt_upd;
    end

    assign window_done     = in_range && full;
    assign job.channel     = channel;
    assign job.sum_val     = sum_upd;
    assign job.min_val     = min_upd;
    assign job.max_val     = max_upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < atm_pkg::CHANNELS; i++) begin
                sum_reg[i] <= '0;
                min_reg[i] <= atm_pkg::MIN_INIT;
                max_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end else if (upd_en && in_range) begin
            sum_reg[idx] <= sum_next;
            min_reg[idx] <= min_next;
            max_reg[idx] <= max_next;
            cnt_reg[idx] <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/atm_text_fmt.sv =====
module atm_text_fmt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        job_valid,
    input  atm_pkg::job_t               job,
    output logic                        job_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_ascii_char,
    output logic [atm_pkg::CH_W-1:0]    m_out_channel,
    output logic [atm_pkg::MV_W-1:0]    m_mean_millivolts,
    output logic                        m_last
);

    // stage a: completed window
    logic          a_valid_reg;
    atm_pkg::job_t a_job_reg;
    // stage b: mean
    logic                       b_valid_reg;
    logic [atm_pkg::MV_W-1:0]   b_mean_reg;
    logic [atm_pkg::CH_W-1:0]   b_ch_reg;
    // emitter
    logic                          e_valid_reg;
    logic [atm_pkg::IDX_W-1:0]     e_idx_reg;
    logic [atm_pkg::MV_W-1:0]      e_mean_reg;
    logic [atm_pkg::CH_W-1:0]      e_ch_reg;
    logic [atm_pkg::Q1000_W-1:0]   e_q1000_reg;
    logic [atm_pkg::Q100_W-1:0]    e_q100_reg;
    logic [atm_pkg::Q10_W-1:0]     e_q10_reg;

    logic [atm_pkg::TRIM_W-1:0]      trim;
    logic [atm_pkg::SUM_W-1:0]       rest;
    logic [atm_pkg::MEAN_PROD_W-1:0] mean_prod;
    logic [atm_pkg::MV_W-1:0]        mean_a;
    logic [atm_pkg::DEC_PROD_W-1:0]  p1000, p100, p10;
    logic [atm_pkg::Q100_W-1:0]      hund_full;
    logic [atm_pkg::Q10_W-1:0]       tens_full;
    logic [atm_pkg::MV_W-1:0]        ones_full;
    logic [3:0]                      digit_sel;

    logic m_fire, e_done, e_free, b_adv, b_free, a_adv;

    assign m_fire    = e_valid_reg && m_ready;
    assign e_done    = m_fire && (e_idx_reg == atm_pkg::BYTE_CR);
    assign e_free    = !e_valid_reg || e_done;
    assign b_adv     = b_valid_reg && e_free;
    assign b_free    = !b_valid_reg || b_adv;
    assign a_adv     = a_valid_reg && b_free;
    assign job_ready = !a_valid_reg || a_adv;

    // trimmed mean: drop min and max, divide the rest
    always_comb begin
        trim = atm_pkg::TRIM_W'(a_job_reg.min_val) + atm_pkg::TRIM_W'(a_job_reg.max_val);
        rest = (a_job_reg.sum_val >= atm_pkg::SUM_W'(trim))
             ? a_job_reg.sum_val - atm_pkg::SUM_W'(trim) : '0;
        mean_prod = atm_pkg::MEAN_PROD_W'(rest) * atm_pkg::MEAN_PROD_W'(atm_pkg::MEAN_REC);
        mean_a    = atm_pkg::MV_W'(mean_prod >> atm_pkg::MEAN_SH);
    end

    // quotients by 1000, 100 and 10
    assign p1000 = atm_pkg::DEC_PROD_W'(b_mean_reg)
                 * atm_pkg::DEC_PROD_W'(atm_pkg::REC_1000);
    assign p100  = atm_pkg::DEC_PROD_W'(b_mean_reg)
                 * atm_pkg::DEC_PROD_W'(atm_pkg::REC_100);
    assign p10   = atm_pkg::DEC_PROD_W'(b_mean_reg)
                 * atm_pkg::DEC_PROD_W'(atm_pkg::REC_10);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            e_idx_reg   <= atm_pkg::BYTE_HASH;
        end else begin
            if (job_valid && job_ready) begin
                a_valid_reg <= 1'b1;
            end else if (a_adv) begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv) begin
                b_valid_reg <= 1'b1;
            end else if (b_adv) begin
                b_valid_reg <= 1'b0;
            end
            if (b_adv) begin
                e_valid_reg <= 1'b1;
            end else if (e_done) begin
                e_valid_reg <= 1'b0;
            end
            if (m_fire) begin
                e_idx_reg <= e_idx_reg + atm_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_valid && job_ready) begin
            a_job_reg <= job;
        end
        if (a_adv) begin
            b_mean_reg <= mean_a;
            b_ch_reg   <= a_job_reg.channel;
        end
        if (b_adv) begin
            e_mean_reg  <= b_mean_reg;
            e_ch_reg    <= b_ch_reg;
            e_q1000_reg <= atm_pkg::Q1000_W'(p1000 >> atm_pkg::SH_1000);
            e_q100_reg  <= atm_pkg::Q100_W'(p100 >> atm_pkg::SH_100);
            e_q10_reg   <= atm_pkg::Q10_W'(p10 >> atm_pkg::SH_10);
        end
    end

    // digits as differences of neighboring quotients
    always_comb begin
        hund_full = e_q100_reg
                  - (atm_pkg::Q100_W'(e_q1000_reg) << 3)
                  - (atm_pkg::Q100_W'(e_q1000_reg) << 1);
        tens_full = e_q10_reg
                  - (atm_pkg::Q10_W'(e_q100_reg) << 3)
                  - (atm_pkg::Q10_W'(e_q100_reg) << 1);
        ones_full = e_mean_reg
                  - (atm_pkg::MV_W'(e_q10_reg) << 3)
                  - (atm_pkg::MV_W'(e_q10_reg) << 1);
        case (e_idx_reg)
            atm_pkg::BYTE_THOU: digit_sel = 4'(e_q1000_reg);
            atm_pkg::BYTE_HUND: digit_sel = hund_full[3:0];
            atm_pkg::BYTE_TENS: digit_sel = tens_full[3:0];
            default:            digit_sel = ones_full[3:0];
        endcase
        case (e_idx_reg)
            atm_pkg::BYTE_HASH: m_ascii_char = atm_pkg::CHAR_HASH;
            atm_pkg::BYTE_DOT:  m_ascii_char = atm_pkg::CHAR_DOT;
            atm_pkg::BYTE_PCT:  m_ascii_char = atm_pkg::CHAR_PCT;
            atm_pkg::BYTE_CR:   m_ascii_char = atm_pkg::CHAR_CR;
            default:            m_ascii_char = atm_pkg::CHAR_ZERO + {4'b0000, digit_sel};
        endcase
    end

    assign m_valid           = e_valid_reg;
    assign m_out_channel     = e_ch_reg;
    assign m_mean_millivolts = e_mean_reg;
    assign m_last            = e_idx_reg == atm_pkg::BYTE_CR;

endmodule
